// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== sv/plm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_pkg
// Shared codes, widths and the control bundle for the list editor cells.
// ----------------------------------------------------------------------------
package plm_pkg;

    localparam int CAPACITY_DEF = 128;
    // Widest control fields, sized for the largest supported list.
    localparam int CNT_MAX_W    = 11;

    localparam logic [2:0] OP_CLEAR     = 3'd0;
    localparam logic [2:0] OP_APPEND    = 3'd1;
    localparam logic [2:0] OP_INSERT    = 3'd2;
    localparam logic [2:0] OP_OVERWRITE = 3'd3;
    localparam logic [2:0] OP_DELETE    = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_WRITE = 3'd1;
    localparam logic [2:0] ACT_INS   = 3'd2;
    localparam logic [2:0] ACT_DEL   = 3'd3;
    localparam logic [2:0] ACT_LOAD  = 3'd4;
    localparam logic [2:0] ACT_SHIFT = 3'd5;

    typedef struct packed {
        logic [2:0]           act;
        logic [CNT_MAX_W-1:0] pos_idx;  // 0-based target cell
        logic [CNT_MAX_W-1:0] count;    // entry count before the item
        logic [31:0]          val;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ===== sv/plm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_cell
// One list slot: holds a word and a read lane stage, takes from neighbors.
// ----------------------------------------------------------------------------
module plm_cell
    import plm_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic        i_clk,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic [31:0] i_left_word,
    input  wire logic [31:0] i_right_word,
    input  wire logic [31:0] i_right_lane,
    output logic      [31:0] o_word,
    output logic      [31:0] o_lane
);

    localparam logic [CNT_MAX_W-1:0] K = CNT_MAX_W'(IDX);

    logic [31:0] r_word, n_word;
    logic [31:0] r_lane, n_lane;

    always_comb begin
        n_word = r_word;
        n_lane = r_lane;
        case (i_ctl.act)
            ACT_WRITE: begin
                if (K == i_ctl.pos_idx) n_word = i_ctl.val;
            end
            ACT_INS: begin
                if (K == i_ctl.pos_idx) begin
                    n_word = i_ctl.val;
                end else if (K > i_ctl.pos_idx && K <= i_ctl.count) begin
                    n_word = i_left_word;
                end
            end
            ACT_DEL: begin
                if (K >= i_ctl.pos_idx && (K + 1'b1) < i_ctl.count) n_word = i_right_word;
            end
            ACT_LOAD:  n_lane = r_word;
            ACT_SHIFT: n_lane = i_right_lane;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_lane <= n_lane;
    end

    assign o_word = r_word;
    assign o_lane = r_lane;

endmodule
`default_nettype wire

// ===== sv/plm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_ctrl
// Decodes items, keeps the entry count, steers the cells, holds the result.
// ----------------------------------------------------------------------------
module plm_ctrl
    import plm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_item_value,
    input  wire logic [31:0] i_lane0,
    output t_cell_ctl        o_ctl,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [1:0]  o_status,
    output logic      [31:0] o_read_value,
    output logic      [7:0]  o_count_after
);

    localparam int IDXW = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int CW   = ((CNTW > 8) ? CNTW : 8) + 1;
    localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic            r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [IDXW-1:0] r_rd_cnt, n_rd_cnt;
    logic            r_out_valid, n_out_valid;
    logic [1:0]      r_status, n_status;
    logic [31:0]     r_rd_val, n_rd_val;
    logic [7:0]      r_cnt_out, n_cnt_out;

    logic            w_accept;
    logic [CW-1:0]   w_pos, w_cnt, w_pc;

    assign o_ready  = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_accept = i_valid && o_ready;
    assign w_pos    = CW'(i_position);
    assign w_cnt    = CW'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_cnt    = r_rd_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_rd_val    = r_rd_val;
        n_cnt_out   = r_cnt_out;
        o_ctl.act     = ACT_NONE;
        o_ctl.pos_idx = '0;
        o_ctl.count   = CNT_MAX_W'(r_count);
        o_ctl.val     = i_item_value;
        w_pc          = '0;

        if (r_state == S_READ) begin
            if (r_rd_cnt == '0) begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_rd_val    = i_lane0;
            end else begin
                o_ctl.act = ACT_SHIFT;
                n_rd_cnt  = r_rd_cnt - 1'b1;
            end
        end else if (w_accept) begin
            n_status = ST_OK;
            n_rd_val = '0;
            case (i_operation)
                OP_CLEAR: n_count = '0;
                OP_APPEND: begin
                    if (w_cnt >= CAP_W) begin
                        n_status = ST_FULL;
                    end else begin
                        o_ctl.act     = ACT_WRITE;
                        o_ctl.pos_idx = CNT_MAX_W'(r_count);
                        n_count       = r_count + 1'b1;
                    end
                end
                OP_INSERT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_cnt >= CAP_W) begin
                        n_status = ST_FULL;
                    end else begin
                        // clamp position to 1..count+1
                        w_pc = (w_pos == '0) ? CW'(1) : w_pos;
                        if (w_pc > w_cnt + 1'b1) w_pc = w_cnt + 1'b1;
                        o_ctl.act     = ACT_INS;
                        o_ctl.pos_idx = CNT_MAX_W'(w_pc - 1'b1);
                        n_count       = r_count + 1'b1;
                    end
                end
                OP_OVERWRITE, OP_DELETE, OP_READ: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_pos == '0 || w_pos > w_cnt) begin
                        n_status = ST_BADPOS;
                    end else begin
                        o_ctl.pos_idx = CNT_MAX_W'(w_pos - 1'b1);
                        if (i_operation == OP_OVERWRITE) begin
                            o_ctl.act = ACT_WRITE;
                        end else if (i_operation == OP_DELETE) begin
                            o_ctl.act = ACT_DEL;
                            n_count   = r_count - 1'b1;
                        end else begin
                            // lanes copy the words, then walk toward cell 0
                            o_ctl.act = ACT_LOAD;
                            n_rd_cnt  = IDXW'(w_pos - 1'b1);
                            n_state   = S_READ;
                        end
                    end
                end
                default: ;
            endcase
            n_cnt_out = 8'(n_count);
            if (n_state == S_IDLE) n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rd_cnt    <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rd_cnt    <= n_rd_cnt;
        end
        r_status  <= n_status;
        r_rd_val  <= n_rd_val;
        r_cnt_out <= n_cnt_out;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_rd_val;
    assign o_count_after = r_cnt_out;

endmodule
`default_nettype wire

// ===== sv/positional_list_editor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_editor_top
// Ordered list of signed words with clear, append, insert, overwrite,
// delete and read at a 1-based position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells; insert and delete move every
// later entry by one cell at the accepting edge, so clear, append, insert,
// overwrite, delete and any refused item have their result registered at
// that same edge. A successful read at position p copies the words into a
// read lane that advances one cell per cycle toward cell 0, where the word
// is taken and registered as the result. Each item gives exactly one result;
// a new item is taken only when no read is under way and no result waits or
// the waiting one leaves in the same cycle.
module positional_list_editor_top
    import plm_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [7:0]  i_position,
    input  wire logic [31:0] i_item_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic      [1:0]  o_status,
    output logic signed [31:0] o_read_value,
    output logic      [7:0]  o_count_after
);

    localparam logic [7:0] CAP8 = 8'(CAPACITY);

    t_cell_ctl   w_ctl;
    logic [31:0] w_word [CAPACITY];
    logic [31:0] w_lane [CAPACITY];
    logic [31:0] w_rd_val;

    plm_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .i_lane0      (w_lane[0]),
        .o_ctl        (w_ctl),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_read_value (w_rd_val),
        .o_count_after(o_count_after)
    );

    assign o_read_value = w_rd_val;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [31:0] w_left, w_right, w_rlane;
        if (k == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid
            assign w_left = w_word[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_right = '0;
            assign w_rlane = '0;
        end else begin : g_inner
            assign w_right = w_word[k+1];
            assign w_rlane = w_lane[k+1];
        end
        plm_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_left_word (w_left),
            .i_right_word(w_right),
            .i_right_lane(w_rlane),
            .o_word      (w_word[k]),
            .o_lane      (w_lane[k])
        );
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(a_no_shift_when_ready, o_ready && w_ctl.act == ACT_SHIFT, "lane shift while idle")
    `ASSERT_IMPL(a_refused_reads_zero, o_valid && o_status != ST_OK, o_read_value == '0, "nonzero read value on refused item")
    `ASSERT_IMPL(a_full_count, o_valid && o_status == ST_FULL, o_count_after == CAP8, "full status with count below capacity")
    `ASSERT_IMPL(a_empty_count, o_valid && o_status == ST_EMPTY, o_count_after == 8'd0, "empty status with nonzero count")

endmodule
`default_nettype wire
